[rtl/mht_pkg.sv]
package mht_pkg;

    // Field widths
    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int TIME_W = 32;

    // Address screening: low byte that marks a loopback-style address
    localparam logic [7:0] IP_LOOP_BYTE = 8'h7F;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_SET    = 1'b1;

    // One stored host record
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] seen;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture request, clear scan state
        logic issue;    // read the next entry and advance the scan
        logic fill;     // insert into the first free slot if needed
        logic publish;  // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic skip;     // set with a rejected address: no scan
        logic last;     // the scan is at the final entry
    } t_sts;

endpackage

[rtl/mht_ram.sv]
module mht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mht_ctrl.sv]
module mht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  mht_pkg::t_sts i_sts,
    output mht_pkg::t_cmd o_cmd
);
    import mht_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FILL,
        S_POST
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    t_cmd   cmd;

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld & i_stall;
        cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.skip) begin
                    n_state = S_POST;
                end else begin
                    cmd.issue = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_FILL;
            end
            S_FILL: begin
                cmd.fill = 1'b1;
                n_state  = S_POST;
            end
            S_POST: begin
                // hold until the output register is free
                if (!r_out_vld || !i_stall) begin
                    cmd.publish = 1'b1;
                    n_out_vld   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_cmd   = cmd;

endmodule

[rtl/mht_dp.sv]
module mht_dp #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mht_pkg::t_cmd               i_cmd,
    output mht_pkg::t_sts               o_sts,
    input  logic                        i_op,
    input  logic [mht_pkg::MAC_W-1:0]   i_mac,
    input  logic [mht_pkg::IP_W-1:0]    i_ip,
    input  logic [mht_pkg::PORT_W-1:0]  i_port,
    input  logic                        i_update_ip,
    input  logic                        i_auth,
    input  logic [mht_pkg::TIME_W-1:0]  i_now,
    output logic                        o_hit,
    output logic [mht_pkg::IP_W-1:0]    o_found_ip,
    output logic [mht_pkg::PORT_W-1:0]  o_found_port,
    output logic                        o_modified
);
    import mht_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Captured request
    logic              r_op;
    logic [MAC_W-1:0]  r_mac;
    logic [IP_W-1:0]   r_ip;
    logic [PORT_W-1:0] r_port;
    logic              r_upd;
    logic              r_auth;
    logic [TIME_W-1:0] r_now;

    // Scan state
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [IDX_W-1:0]   r_chk_idx;
    logic               r_chk_vld;
    logic               r_found;
    logic               r_free_vld;
    logic [IDX_W-1:0]   r_free_idx;

    // Working result
    logic              r_hit;
    logic [IP_W-1:0]   r_fip;
    logic [PORT_W-1:0] r_fport;
    logic              r_mod;

    // Output register
    logic              r_out_hit;
    logic [IP_W-1:0]   r_out_ip;
    logic [PORT_W-1:0] r_out_port;
    logic              r_out_mod;

    logic [REC_W-1:0] rd_data;
    t_rec             rec;
    t_rec             upd_rec;
    t_rec             new_rec;
    logic             cur_vld;
    logic             mac_eq;
    logic             ipport_eq;
    logic             purge;
    logic             exact;
    logic             mac_upd;
    logic             chk_wr;
    logic             do_fill;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic             ip_bad;

    // Reject zero, broadcast and loopback-style addresses
    assign ip_bad = (r_ip == '0) || (r_ip == '1) || (r_ip[7:0] == IP_LOOP_BYTE);

    assign o_sts.skip = (r_op == OP_SET) && ip_bad;
    assign o_sts.last = (r_rd_idx == LAST_IDX);

    // Evaluate the entry whose record arrives this cycle
    always_comb begin
        rec       = t_rec'(rd_data);
        cur_vld   = r_chk_vld && r_valid[r_chk_idx];
        mac_eq    = (rec.mac == r_mac);
        ipport_eq = (rec.ip == r_ip) && (rec.port == r_port);
        purge     = (r_op == OP_SET) && r_auth && cur_vld && ipport_eq && !mac_eq;
        exact     = (r_op == OP_SET) && cur_vld && mac_eq && ipport_eq;
        mac_upd   = (r_op == OP_SET) && cur_vld && mac_eq && r_upd;
        chk_wr    = (exact && r_auth) || mac_upd;

        upd_rec      = rec;
        upd_rec.seen = r_now;
        if (mac_upd) begin
            upd_rec.ip   = r_ip;
            upd_rec.port = r_port;
        end

        new_rec.mac  = r_mac;
        new_rec.ip   = r_ip;
        new_rec.port = r_port;
        new_rec.seen = r_now;

        do_fill = i_cmd.fill && (r_op == OP_SET) && !r_found && r_free_vld;
    end

    // One write port: refresh or rewrite during the scan, insert afterward
    always_comb begin
        ram_we    = chk_wr || do_fill;
        ram_waddr = do_fill ? r_free_idx : r_chk_idx;
        ram_wdata = do_fill ? REC_W'(new_rec) : REC_W'(upd_rec);
    end

    mht_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    // Valid bits and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= i_cmd.issue;
            if (purge) begin
                r_valid[r_chk_idx] <= 1'b0;
            end
            if (do_fill) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    // Request capture, scan pointers and working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_mac      <= i_mac;
            r_ip       <= i_ip;
            r_port     <= i_port;
            r_upd      <= i_update_ip;
            r_auth     <= i_auth;
            r_now      <= i_now;
            r_rd_idx   <= '0;
            r_found    <= 1'b0;
            r_free_vld <= 1'b0;
            r_hit      <= 1'b0;
            r_fip      <= (i_op == OP_SET) ? '0 : '1;
            r_fport    <= (i_op == OP_SET) ? '0 : '1;
            r_mod      <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_chk_idx <= r_rd_idx;
                r_rd_idx  <= r_rd_idx + 1'b1;
            end
            // lookup: keep the first valid MAC match
            if ((r_op == OP_LOOKUP) && cur_vld && mac_eq && !r_hit) begin
                r_hit   <= 1'b1;
                r_fip   <= rec.ip;
                r_fport <= rec.port;
            end
            if (exact || mac_upd) begin
                r_found <= 1'b1;
            end
            // first slot that is free once purging is done
            if (r_chk_vld && !r_free_vld && (!r_valid[r_chk_idx] || purge)) begin
                r_free_vld <= 1'b1;
                r_free_idx <= r_chk_idx;
            end
            if (purge || chk_wr || do_fill) begin
                r_mod <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_hit  <= r_hit;
            r_out_ip   <= r_fip;
            r_out_port <= r_fport;
            r_out_mod  <= r_mod;
        end
    end

    assign o_hit        = r_out_hit;
    assign o_found_ip   = r_out_ip;
    assign o_found_port = r_out_port;
    assign o_modified   = r_out_mod;

endmodule

[rtl/mac_host_table.sv]
// One item at a time: the input stalls from the input transfer until the result is
// published; a set with a rejected address skips the entry scan. The scan reads one
// record per cycle from the table RAM.
// The next item is taken while a finished result waits in the output register.
// Reset (synchronous, active low) clears all valid marks and the handshake state.
module mac_host_table #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [mht_pkg::MAC_W-1:0]   i_mac,
    input  logic [mht_pkg::IP_W-1:0]    i_ip,
    input  logic [mht_pkg::PORT_W-1:0]  i_port,
    input  logic                        i_update_ip,
    input  logic                        i_auth,
    input  logic [mht_pkg::TIME_W-1:0]  i_now,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_hit,
    output logic [mht_pkg::IP_W-1:0]    o_found_ip,
    output logic [mht_pkg::PORT_W-1:0]  o_found_port,
    output logic                        o_modified
);
    import mht_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    mht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    mht_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (i_op),
        .i_mac        (i_mac),
        .i_ip         (i_ip),
        .i_port       (i_port),
        .i_update_ip  (i_update_ip),
        .i_auth       (i_auth),
        .i_now        (i_now),
        .o_hit        (o_hit),
        .o_found_ip   (o_found_ip),
        .o_found_port (o_found_port),
        .o_modified   (o_modified)
    );

`ifndef SYNTHESIS
    // Scan and insert never share a cycle
    a_issue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.issue && w_cmd.fill))
        else $error("scan read and insert in the same cycle");

    // A published result shows up on the output
    a_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.publish |=> o_valid)
        else $error("published result not valid");

    // An input transfer makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after input transfer");

    // A taken result clears unless a new one is published
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !w_cmd.publish) |=> !o_valid)
        else $error("result repeated after output transfer");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import mht_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int RANDOM_ITEMS = 1440;
    localparam int QUIET_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 30;

    typedef struct packed {
        logic              op;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic              update_ip;
        logic              auth;
        logic [TIME_W-1:0] now;
    } host_req_t;

    typedef struct packed {
        logic              hit;
        logic [IP_W-1:0]   found_ip;
        logic [PORT_W-1:0] found_port;
        logic              modified;
    } host_rsp_t;

    // Host table mirror and queue of pending results
    class host_scoreboard;
        bit                ent_valid [ENTRIES];
        bit [MAC_W-1:0]    ent_mac   [ENTRIES];
        bit [IP_W-1:0]     ent_ip    [ENTRIES];
        bit [PORT_W-1:0]   ent_port  [ENTRIES];
        bit [TIME_W-1:0]   ent_seen  [ENTRIES];
        host_rsp_t         expected_q[$];
        int                errors;

        task report(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // First valid entry with the key wins
        function host_rsp_t lookup_host(logic [MAC_W-1:0] key);
            host_rsp_t rsp;
            rsp = '0;
            rsp.found_ip   = '1;
            rsp.found_port = '1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (ent_valid[i] && ent_mac[i] == key) begin
                    rsp.hit        = 1'b1;
                    rsp.found_ip   = ent_ip[i];
                    rsp.found_port = ent_port[i];
                    return rsp;
                end
            end
            return rsp;
        endfunction

        // Purge, match/refresh, rewrite, then insert; returns the changed flag
        function bit store_host(host_req_t r);
            bit changed;
            bit found;
            changed = 1'b0;
            found   = 1'b0;
            if (r.ip == '0 || r.ip == '1 || r.ip[7:0] == IP_LOOP_BYTE)
                return 1'b0;
            if (r.auth) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (ent_valid[i] && ent_ip[i] == r.ip && ent_port[i] == r.port &&
                        ent_mac[i] != r.mac) begin
                        ent_valid[i] = 1'b0;
                        changed      = 1'b1;
                    end
                end
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (!ent_valid[i])
                    continue;
                if (ent_ip[i] == r.ip && ent_mac[i] == r.mac && ent_port[i] == r.port) begin
                    found = 1'b1;
                    if (r.auth) begin
                        ent_seen[i] = r.now;
                        changed     = 1'b1;
                    end
                end
                if (ent_mac[i] == r.mac && r.update_ip) begin
                    ent_seen[i] = r.now;
                    ent_ip[i]   = r.ip;
                    ent_port[i] = r.port;
                    found       = 1'b1;
                    changed     = 1'b1;
                end
            end
            if (!found) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!ent_valid[i]) begin
                        ent_valid[i] = 1'b1;
                        ent_mac[i]   = r.mac;
                        ent_ip[i]    = r.ip;
                        ent_port[i]  = r.port;
                        ent_seen[i]  = r.now;
                        changed      = 1'b1;
                        break;
                    end
                end
            end
            return changed;
        endfunction

        function void note_input(host_req_t r);
            host_rsp_t rsp;
            rsp = '0;
            if (r.op == OP_LOOKUP)
                rsp = lookup_host(r.mac);
            else
                rsp.modified = store_host(r);
            expected_q.push_back(rsp);
        endfunction

        task check_result(host_rsp_t got);
            host_rsp_t exp;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result hit=%0b ip=%h port=%h modified=%0b",
                                 got.hit, got.found_ip, got.found_port, got.modified));
                return;
            end
            exp = expected_q.pop_front();
            if (got.hit !== exp.hit)
                report($sformatf("hit got %0b want %0b", got.hit, exp.hit));
            if (got.found_ip !== exp.found_ip)
                report($sformatf("found_ip got %h want %h", got.found_ip, exp.found_ip));
            if (got.found_port !== exp.found_port)
                report($sformatf("found_port got %h want %h", got.found_port, exp.found_port));
            if (got.modified !== exp.modified)
                report($sformatf("modified got %0b want %0b", got.modified, exp.modified));
        endtask
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic              i_op        = OP_LOOKUP;
    logic [MAC_W-1:0]  i_mac       = '0;
    logic [IP_W-1:0]   i_ip        = '0;
    logic [PORT_W-1:0] i_port      = '0;
    logic              i_update_ip = 1'b0;
    logic              i_auth      = 1'b0;
    logic [TIME_W-1:0] i_now       = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic              o_hit;
    logic [IP_W-1:0]   o_found_ip;
    logic [PORT_W-1:0] o_found_port;
    logic              o_modified;

    host_scoreboard    sb = new;
    bit                quiet = 1'b0;
    int                stall_left = 0;
    int                cycles = 0;

    bit [MAC_W-1:0]    mac_pool  [20];
    bit [IP_W-1:0]     ip_pool   [8];
    bit [PORT_W-1:0]   port_pool [4];
    bit [MAC_W-1:0]    recent_macs[$];

    always #6 i_clk = ~i_clk;

    mac_host_table #(
        .ENTRIES      (ENTRIES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_mac        (i_mac),
        .i_ip         (i_ip),
        .i_port       (i_port),
        .i_update_ip  (i_update_ip),
        .i_auth       (i_auth),
        .i_now        (i_now),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_found_ip   (o_found_ip),
        .o_found_port (o_found_port),
        .o_modified   (o_modified)
    );

    // Hold off result transfers in random bursts
    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 10);
        end else begin
            i_stall    <= 1'b0;
            stall_left <= $urandom_range(0, 30);
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        host_rsp_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_hit, o_found_ip, o_found_port, o_modified};
            sb.check_result(got);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function host_req_t mk(logic op, logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
                           logic [PORT_W-1:0] port, logic upd, logic auth);
        host_req_t r;
        r.op        = op;
        r.mac       = mac;
        r.ip        = ip;
        r.port      = port;
        r.update_ip = upd;
        r.auth      = auth;
        r.now       = $urandom;
        return r;
    endfunction

    function bit [MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Build one random request; fill mode inserts fresh hosts without purging
    function host_req_t make_item(bit fill_mode);
        host_req_t     r;
        bit [IP_W-1:0] bad_ip;
        int            pick;
        r.now = $urandom;
        if (fill_mode) begin
            r.op        = ($urandom_range(0, 9) < 8) ? OP_SET : OP_LOOKUP;
            r.update_ip = ($urandom_range(0, 9) == 0);
            r.auth      = 1'b0;
        end else begin
            r.op        = $urandom_range(0, 1) ? OP_SET : OP_LOOKUP;
            r.update_ip = ($urandom_range(0, 9) < 3);
            r.auth      = ($urandom_range(0, 9) < 4);
        end
        pick = $urandom_range(0, 99);
        if (r.op == OP_LOOKUP && recent_macs.size() > 0 && pick < 60)
            r.mac = recent_macs[$urandom_range(0, recent_macs.size() - 1)];
        else if (fill_mode && pick < 70)
            r.mac = rand_mac();
        else if (pick < 90)
            r.mac = mac_pool[$urandom_range(0, 19)];
        else
            r.mac = rand_mac();
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            r.ip = ip_pool[$urandom_range(0, 7)];
        end else if (pick < 87) begin
            bad_ip = $urandom;
            bad_ip[7:0] = IP_LOOP_BYTE;
            case ($urandom_range(0, 2))
                0: r.ip = '0;
                1: r.ip = '1;
                default: r.ip = bad_ip;
            endcase
        end else begin
            r.ip = $urandom;
        end
        r.port = ($urandom_range(0, 99) < 85) ? port_pool[$urandom_range(0, 3)]
                                              : 16'($urandom);
        if (r.op == OP_SET) begin
            recent_macs.push_back(r.mac);
            if (recent_macs.size() > 32)
                void'(recent_macs.pop_front());
        end
        return r;
    endfunction

    function int idle_gap(int pct);
        if (quiet || $urandom_range(0, 99) >= pct)
            return 0;
        return $urandom_range(1, 11);
    endfunction

    // Present one request and hold it until the transfer
    task send_item(host_req_t r, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= r.op;
        i_mac       <= r.mac;
        i_ip        <= r.ip;
        i_port      <= r.port;
        i_update_ip <= r.update_ip;
        i_auth      <= r.auth;
        i_now       <= r.now;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(r);
    endtask

    // Drop valid and wait for every outstanding result
    task drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        host_req_t      directed_q[$];
        bit [IP_W-1:0]  ip_tmp;
        int             mode;
        int             idle_pct;

        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int i = 2; i < 20; i++)
            mac_pool[i] = rand_mac();
        for (int i = 0; i < 8; i++) begin
            ip_tmp = $urandom;
            if (ip_tmp[7:0] == IP_LOOP_BYTE || ip_tmp == '1 || ip_tmp == '0)
                ip_tmp[7:0] = 8'h01;
            ip_pool[i] = ip_tmp;
        end
        port_pool[0] = '0;
        port_pool[1] = '1;
        port_pool[2] = $urandom;
        port_pool[3] = $urandom;

        // Directed: empty lookup, rejected addresses, refresh, rewrite, purge
        directed_q.push_back(mk(OP_LOOKUP, '1, '0, '0, 1'b0, 1'b0));
        directed_q.push_back(mk(OP_SET, 48'h0123_4567_89ab, '0, 16'h1234, 1'b0, 1'b0));
        directed_q.push_back(mk(OP_SET, 48'h0123_4567_89ab, '1, 16'h1234, 1'b1, 1'b1));
        directed_q.push_back(mk(OP_SET, 48'h0123_4567_89ab, 32'hc0a8_017f, 16'h1234,
                                1'b0, 1'b1));
        directed_q.push_back(mk(OP_SET, '1, 32'h0a00_0001, '1, 1'b0, 1'b0));
        directed_q.push_back(mk(OP_LOOKUP, '1, '0, '0, 1'b0, 1'b0));
        directed_q.push_back(mk(OP_SET, '1, 32'h0a00_0001, '1, 1'b0, 1'b1));
        directed_q.push_back(mk(OP_SET, '1, 32'h0a00_0001, '1, 1'b0, 1'b0));
        directed_q.push_back(mk(OP_SET, '1, 32'h0a00_0002, '0, 1'b1, 1'b0));
        directed_q.push_back(mk(OP_LOOKUP, '1, '1, '1, 1'b1, 1'b1));
        directed_q.push_back(mk(OP_SET, '0, 32'h0a00_0002, '0, 1'b0, 1'b1));
        directed_q.push_back(mk(OP_LOOKUP, '1, '0, '0, 1'b0, 1'b0));
        directed_q.push_back(mk(OP_LOOKUP, '0, '0, '0, 1'b0, 1'b0));
        directed_q.push_back(mk(OP_SET, '0, 32'h0a00_0002, '0, 1'b1, 1'b1));
        directed_q.push_back(mk(OP_SET, 48'h0000_0000_0001, 32'hffff_ff7e, 16'h0001,
                                1'b0, 1'b0));
        directed_q.push_back(mk(OP_SET, 48'h8000_0000_0000, 32'h8000_0000, 16'h8000,
                                1'b1, 1'b0));
        directed_q.push_back(mk(OP_LOOKUP, 48'h8000_0000_0000, '0, '0, 1'b0, 1'b0));

        // Hold reset, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_q[k])
            send_item(directed_q[k], idle_gap(25));
        drain_results();

        // Each random block of 40 items picks table filling or mixed traffic at random
        mode     = 0;
        idle_pct = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                mode = $urandom_range(0, 3);
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 12;
                    default: idle_pct = 35;
                endcase
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if (n % 337 == 336)
                drain_results();
            send_item(make_item(mode == 0), idle_gap(idle_pct));
        end

        // Wait out the remaining results and the scan latency
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (ENTRIES + 10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
